[rtl/core/lc_meter_calculator_macros.svh]
// assertion helpers for the lc meter calculator
`ifndef LC_METER_CALCULATOR_MACROS_SVH
`define LC_METER_CALCULATOR_MACROS_SVH

// clocked check, off while in reset
`define LCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define LCM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/lcm_pkg.sv]
package lcm_pkg;

  localparam int CountBits = 24;
  localparam int ValueBits = 48;
  localparam int CrefBits  = 30;
  localparam int SqBits    = 2 * CountBits;
  localparam int FracBits  = 32;
  localparam int DivBits   = SqBits + ValueBits + FracBits;
  localparam int MulBits   = ValueBits;

  localparam logic [CrefBits-1:0] CrefReset = CrefBits'(1000000);
  localparam logic [79:0] LsConst = 80'd1013211836423377714438794;

  localparam logic [63:0] Thr1e5  = 64'd100000;
  localparam logic [63:0] Thr1e8  = 64'd100000000;
  localparam logic [63:0] Thr1e11 = 64'd100000000000;

  localparam logic [1:0] MODE_REF = 2'd0;
  localparam logic [1:0] MODE_CAL = 2'd1;
  localparam logic [1:0] MODE_IND = 2'd2;
  localparam logic [1:0] MODE_CAP = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_IND = 2'd1;
  localparam logic [1:0] ST_CAP_NEG = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  localparam logic [1:0] DEC_BASE  = 2'd0;
  localparam logic [1:0] DEC_NANO  = 2'd1;
  localparam logic [1:0] DEC_MICRO = 2'd2;
  localparam logic [1:0] DEC_MILLI = 2'd3;

  typedef struct packed {
    logic [1:0]           mode;
    logic [CountBits-1:0] count;
  } in_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] value;
    logic [1:0]                  decade;
    logic [1:0]                  status;
  } out_t;

endpackage

[rtl/core/lcm_mul.sv]
module lcm_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lcm_pkg::DivBits-1:0] a_i,
  input  logic [lcm_pkg::MulBits-1:0] b_i,
  output logic                        done_o,
  output logic [lcm_pkg::DivBits-1:0] p_o
);

  localparam int CntW = $clog2(lcm_pkg::MulBits + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic [lcm_pkg::DivBits-1:0] a_q;
  logic [lcm_pkg::MulBits-1:0] b_q;
  logic [lcm_pkg::DivBits-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(lcm_pkg::MulBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << 1) + (b_q[lcm_pkg::MulBits-1] ? a_q : '0);
      b_q   <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

[rtl/core/lcm_div.sv]
module lcm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lcm_pkg::DivBits-1:0] num_i,
  input  logic [lcm_pkg::DivBits-1:0] den_i,
  output logic                        done_o,
  output logic [lcm_pkg::DivBits-1:0] quo_o
);

  localparam int CntW = $clog2(lcm_pkg::DivBits + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic [lcm_pkg::DivBits-1:0] num_q;
  logic [lcm_pkg::DivBits-1:0] den_q;
  logic [lcm_pkg::DivBits-1:0] rem_q;
  logic [lcm_pkg::DivBits-1:0] quo_q;
  logic [lcm_pkg::DivBits:0]   trial;
  logic [lcm_pkg::DivBits:0]   diff;
  logic                        ge;

  assign trial = {rem_q, num_q[lcm_pkg::DivBits-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(lcm_pkg::DivBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= ge ? diff[lcm_pkg::DivBits-1:0] : trial[lcm_pkg::DivBits-1:0];
      quo_q <= {quo_q[lcm_pkg::DivBits-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/lc_meter_calculator.sv]
// lc meter calculator: turns oscillator counts from a 0.2 s gate into
// stray values (mode 1) and unknown inductance in pH or capacitance in fF.
// input channel in_valid_i/in_ready_o carries one item (mode, count);
// output channel out_valid_o/out_ready_i carries one result item per input.
// cfg_we_i/cfg_wdata_i write the reference capacitor value in fF at once.
// one item at a time: in_ready_o is high only while the sequencer is idle.
// all steps share one shift-add multiplier and one restoring divider:
//   mode 0 uses only the multiplier, modes 2 and 3 add one quotient,
//   mode 1 adds two.
// results go to an output register; a new item is taken while it waits.
// if the receiver stalls, a finished item waits in the done step until
// the output register frees up.
// reset clears the reference count and the stray values and sets the
// reference capacitor to 1 nF.
`include "lc_meter_calculator_macros.svh"

module lc_meter_calculator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lcm_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lcm_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lcm_pkg::CrefBits-1:0]  cfg_wdata_i
);

  localparam int DW = lcm_pkg::DivBits;
  localparam int VW = lcm_pkg::ValueBits;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_F1SQ = 4'd1;
  localparam logic [3:0] S_NSQ  = 4'd2;
  localparam logic [3:0] S_CMUL = 4'd3;
  localparam logic [3:0] S_CDIV = 4'd4;
  localparam logic [3:0] S_LMUL = 4'd5;
  localparam logic [3:0] S_LDIV = 4'd6;
  localparam logic [3:0] S_RDIV = 4'd7;
  localparam logic [3:0] S_SMUL = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]                        state_q;
  logic [1:0]                        mode_q;
  logic [lcm_pkg::CountBits-1:0]     cnt_q;
  logic [lcm_pkg::SqBits-1:0]        f1sq_q;
  logic [DW-1:0]                     work_q;
  logic                              neg_q;
  logic [VW-1:0]                     cs_q;
  logic [lcm_pkg::CountBits-1:0]     ref_count_q;
  logic [VW-1:0]                     scap_q;
  logic [VW-1:0]                     sind_q;
  logic [lcm_pkg::CrefBits-1:0]      cref_q;
  lcm_pkg::out_t                     res_q;
  lcm_pkg::out_t                     out_q;
  logic                              out_valid_q;

  logic                              mul_start;
  logic [DW-1:0]                     mul_a;
  logic [lcm_pkg::MulBits-1:0]       mul_b;
  logic                              mul_done;
  logic [DW-1:0]                     mul_p;
  logic                              div_start;
  logic [DW-1:0]                     div_num;
  logic [DW-1:0]                     div_den;
  logic                              div_done;
  logic [DW-1:0]                     div_q;

  logic [lcm_pkg::SqBits-1:0]        sq_now;
  logic [VW-1:0]                     cs_pack;
  logic [VW-1:0]                     cs_mag;
  logic [DW-1:0]                     r_m;
  logic                              r_neg;
  logic [VW-1:0]                     base;
  logic [VW-1:0]                     base_mag;
  logic [VW-1:0]                     v_pack;
  logic [VW-1:0]                     v_mag;
  logic [63:0]                       v_mag64;
  logic                              in_acc;
  logic                              out_load;

  function automatic logic [VW-1:0] sat_pack(input logic neg, input logic [DW-1:0] mag);
    logic [DW-1:0] lim;
    logic [DW-1:0] m;
    lim = DW'(1) << (VW - 1);
    if (neg) begin
      m = (mag > lim) ? lim : mag;
      return VW'(DW'(0) - m);
    end
    m = (mag >= lim) ? lim - DW'(1) : mag;
    return m[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] mag_of(input logic [VW-1:0] v);
    return v[VW-1] ? VW'(0) - v : v;
  endfunction

  lcm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  lcm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign sq_now     = mul_p[lcm_pkg::SqBits-1:0];
  assign cs_pack    = sat_pack(neg_q, div_q);
  assign cs_mag     = mag_of(cs_pack);
  assign r_neg      = div_q < (DW'(1) << lcm_pkg::FracBits);
  assign r_m        = r_neg ? (DW'(1) << lcm_pkg::FracBits) - div_q
                            : div_q - (DW'(1) << lcm_pkg::FracBits);
  assign base       = (mode_q == lcm_pkg::MODE_IND) ? sind_q : scap_q;
  assign base_mag   = mag_of(base);
  assign v_pack     = sat_pack(neg_q, mul_p >> lcm_pkg::FracBits);
  assign v_mag      = mag_of(v_pack);
  assign v_mag64    = 64'(v_mag);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      S_IDLE: begin
        mul_start = in_acc;
        mul_a     = DW'(ref_count_q);
        mul_b     = lcm_pkg::MulBits'(ref_count_q);
      end
      S_F1SQ: begin
        mul_start = mul_done;
        mul_a     = DW'(cnt_q);
        mul_b     = lcm_pkg::MulBits'(cnt_q);
      end
      S_NSQ: begin
        if (mode_q == lcm_pkg::MODE_CAL) begin
          mul_start = mul_done && (f1sq_q != sq_now) && (f1sq_q != '0);
          mul_a     = DW'(sq_now);
          mul_b     = lcm_pkg::MulBits'(cref_q);
        end
        div_start = mul_done && (((mode_q == lcm_pkg::MODE_IND) &&
                                  (cnt_q >= lcm_pkg::CountBits'(3))) ||
                                 ((mode_q == lcm_pkg::MODE_CAP) && (cnt_q != '0)));
        div_num   = DW'(f1sq_q) << lcm_pkg::FracBits;
        div_den   = DW'(sq_now);
      end
      S_CMUL: begin
        div_start = mul_done;
        div_num   = mul_p;
        div_den   = work_q;
      end
      S_CDIV: begin
        mul_start = div_done && (div_q != '0);
        mul_a     = DW'(f1sq_q);
        mul_b     = lcm_pkg::MulBits'(cs_mag);
      end
      S_LMUL: begin
        div_start = mul_done;
        div_num   = DW'(lcm_pkg::LsConst);
        div_den   = mul_p;
      end
      S_RDIV: begin
        mul_start = div_done;
        mul_a     = r_m;
        mul_b     = lcm_pkg::MulBits'(base_mag);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ref_count_q <= '0;
      scap_q      <= '0;
      sind_q      <= '0;
      cref_q      <= lcm_pkg::CrefReset;
    end else begin
      if (cfg_we_i) begin
        cref_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (in_acc) state_q <= S_F1SQ;
        S_F1SQ: if (mul_done) state_q <= S_NSQ;
        S_NSQ: begin
          if (mul_done) begin
            if (mul_start) begin
              state_q <= S_CMUL;
            end else if (div_start) begin
              state_q <= S_RDIV;
            end else begin
              state_q <= S_DONE;
            end
            if (mode_q == lcm_pkg::MODE_REF) begin
              ref_count_q <= cnt_q;
            end
          end
        end
        S_CMUL: if (mul_done) state_q <= S_CDIV;
        S_CDIV: if (div_done) state_q <= mul_start ? S_LMUL : S_DONE;
        S_LMUL: if (mul_done) state_q <= S_LDIV;
        S_LDIV: begin
          if (div_done) begin
            scap_q  <= cs_q;
            sind_q  <= sat_pack(neg_q, div_q);
            state_q <= S_DONE;
          end
        end
        S_RDIV: if (div_done) state_q <= S_SMUL;
        S_SMUL: if (mul_done) state_q <= S_DONE;
        S_DONE: if (out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
    unique case (state_q)
      S_IDLE: begin
        mode_q <= in_data_i.mode;
        cnt_q  <= in_data_i.count;
        res_q  <= '{value: '0, decade: lcm_pkg::DEC_BASE, status: lcm_pkg::ST_OK};
      end
      S_F1SQ: f1sq_q <= sq_now;
      S_NSQ: begin
        if (mul_done) begin
          neg_q  <= sq_now > f1sq_q;
          work_q <= (sq_now > f1sq_q) ? DW'(sq_now - f1sq_q) : DW'(f1sq_q - sq_now);
          if (mode_q == lcm_pkg::MODE_CAL && !mul_start) begin
            res_q.status <= lcm_pkg::ST_ZERO;
          end
          if (mode_q == lcm_pkg::MODE_IND && !div_start) begin
            res_q.status <= lcm_pkg::ST_NOT_IND;
          end
          if (mode_q == lcm_pkg::MODE_CAP && !div_start) begin
            res_q.status <= lcm_pkg::ST_ZERO;
          end
        end
      end
      S_CDIV: begin
        if (div_done) begin
          cs_q <= cs_pack;
          if (!mul_start) begin
            res_q.status <= lcm_pkg::ST_ZERO;
          end
        end
      end
      S_RDIV: if (div_done) neg_q <= r_neg ^ base[VW-1];
      S_SMUL: begin
        if (mul_done) begin
          res_q.value <= v_pack;
          if (mode_q == lcm_pkg::MODE_IND) begin
            if (v_pack[VW-1]) begin
              res_q.decade <= lcm_pkg::DEC_BASE;
            end else if (v_mag64 > lcm_pkg::Thr1e8) begin
              res_q.decade <= lcm_pkg::DEC_MILLI;
            end else if (v_mag64 > lcm_pkg::Thr1e5) begin
              res_q.decade <= lcm_pkg::DEC_MICRO;
            end else begin
              res_q.decade <= lcm_pkg::DEC_BASE;
            end
          end else if (v_pack[VW-1] || v_mag == '0) begin
            res_q.status <= lcm_pkg::ST_CAP_NEG;
          end else if (v_mag64 > lcm_pkg::Thr1e11) begin
            res_q.decade <= lcm_pkg::DEC_MILLI;
          end else if (v_mag64 > lcm_pkg::Thr1e8) begin
            res_q.decade <= lcm_pkg::DEC_MICRO;
          end else if (v_mag64 > lcm_pkg::Thr1e5) begin
            res_q.decade <= lcm_pkg::DEC_NANO;
          end else begin
            res_q.decade <= lcm_pkg::DEC_BASE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LCM_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "item taken while busy")
  `LCM_ASSERT(a_load_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE), "result without done step")
  `LCM_ASSERT(a_not_ind_zero, (out_valid_o && out_data_o.status == lcm_pkg::ST_NOT_IND) |-> (out_data_o.value == '0), "not-inductor item with value")
  `LCM_ASSERT(a_decade_ok, (out_valid_o && out_data_o.decade != lcm_pkg::DEC_BASE) |-> (out_data_o.status == lcm_pkg::ST_OK), "decade set on flagged item")

endmodule

[bench/lc_meter_calculator_tb.sv]
`timescale 1ns / 100ps

module lc_meter_calculator_tb;
  import lcm_pkg::*;

  localparam logic [1:0] JOB_ITEM  = 2'd0;
  localparam logic [1:0] JOB_CFG   = 2'd1;
  localparam logic [1:0] JOB_PAUSE = 2'd2;
  localparam int unsigned StallLimit = 20000;
  localparam logic [255:0] SatLim = 256'd1 << (ValueBits - 1);
  localparam logic [255:0] QOne = 256'd1 << FracBits;
  localparam logic [255:0] LsK = 256'(LsConst);
  localparam logic [CrefBits-1:0] CrefMax = CrefBits'(1000000000);

  typedef struct {
    logic [1:0]          kind;
    in_t                 item;
    logic [CrefBits-1:0] cref;
    int unsigned         send_pct;
    int unsigned         recv_pct;
  } job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CrefBits-1:0] cfg_wdata = '0;

  job_t pending[$];
  out_t expected_results[$];

  logic [CrefBits-1:0] cref_ff;
  logic [CountBits-1:0] f1_count;
  logic [ValueBits-1:0] cs_ff;
  logic [ValueBits-1:0] ls_ph;

  int unsigned fill_send, fill_recv, recv_pct;
  int unsigned errors, items_in, results_out, cfg_writes, stall_cycles;

  lc_meter_calculator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [ValueBits-1:0] sat_pack(bit neg, logic [255:0] mag);
    if (neg) begin
      if (mag > SatLim) mag = SatLim;
      sat_pack = ValueBits'(~mag + 256'd1);
    end else begin
      if (mag > SatLim - 1) mag = SatLim - 1;
      sat_pack = mag[ValueBits-1:0];
    end
  endfunction

  function automatic logic [255:0] mag_of(logic [ValueBits-1:0] v);
    logic [ValueBits:0] t;
    t = {1'b0, ~v} + 1'b1;
    mag_of = v[ValueBits-1] ? 256'(t) : 256'(v);
  endfunction

  function automatic logic [ValueBits-1:0] ratio_scale(logic [255:0] f1sq, logic [255:0] nsq,
                                                      logic [ValueBits-1:0] base);
    logic [255:0] r, m;
    bit neg;
    r = (f1sq << FracBits) / nsq;
    if (r >= QOne) begin
      m = r - QOne;
      neg = 1'b0;
    end else begin
      m = QOne - r;
      neg = 1'b1;
    end
    if (base[ValueBits-1]) neg = !neg;
    ratio_scale = sat_pack(neg, (m * mag_of(base)) >> FracBits);
  endfunction

  task automatic predict_meter(in_t it);
    out_t res;
    logic [255:0] f1sq, nsq, den, mag;
    bit neg;
    logic [ValueBits-1:0] cs;
    res = '0;
    f1sq = 256'(f1_count) * 256'(f1_count);
    nsq = 256'(it.count) * 256'(it.count);
    case (it.mode)
      MODE_REF: f1_count = it.count;
      MODE_CAL: begin
        if (f1sq == nsq || f1sq == 0) begin
          res.status = ST_ZERO;
        end else begin
          neg = nsq > f1sq;
          den = neg ? nsq - f1sq : f1sq - nsq;
          cs = sat_pack(neg, (nsq * 256'(cref_ff)) / den);
          mag = mag_of(cs);
          if (mag == 0) begin
            res.status = ST_ZERO;
          end else begin
            cs_ff = cs;
            ls_ph = sat_pack(neg, LsK / (f1sq * mag));
          end
        end
      end
      MODE_IND: begin
        if (it.count < 3) begin
          res.status = ST_NOT_IND;
        end else begin
          res.value = ratio_scale(f1sq, nsq, ls_ph);
          mag = mag_of(res.value);
          if (!res.value[ValueBits-1])
            res.decade = mag > 256'(Thr1e8) ? DEC_MILLI :
                         (mag > 256'(Thr1e5) ? DEC_MICRO : DEC_BASE);
        end
      end
      default: begin
        if (it.count == 0) begin
          res.status = ST_ZERO;
        end else begin
          res.value = ratio_scale(f1sq, nsq, cs_ff);
          mag = mag_of(res.value);
          if (res.value[ValueBits-1] || mag == 0)
            res.status = ST_CAP_NEG;
          else
            res.decade = mag > 256'(Thr1e11) ? DEC_MILLI :
                         (mag > 256'(Thr1e8) ? DEC_MICRO :
                         (mag > 256'(Thr1e5) ? DEC_NANO : DEC_BASE));
        end
      end
    endcase
    expected_results.push_back(res);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic push_item(logic [1:0] mode, logic [CountBits-1:0] count);
    job_t j;
    j.kind = JOB_ITEM;
    j.item.mode = mode;
    j.item.count = count;
    j.cref = '0;
    j.send_pct = fill_send;
    j.recv_pct = fill_recv;
    pending.push_back(j);
  endtask

  task automatic push_ctrl(logic [1:0] kind, logic [CrefBits-1:0] value);
    job_t j;
    j.kind = kind;
    j.item = '0;
    j.cref = value;
    j.send_pct = fill_send;
    j.recv_pct = fill_recv;
    pending.push_back(j);
  endtask

  function automatic logic [CountBits-1:0] rand_count();
    int unsigned w;
    w = $urandom_range(CountBits, 1);
    rand_count = CountBits'($urandom & ((32'd1 << w) - 1));
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit cfg_now;
    cfg_now = 1'b0;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      out_ready <= 1'b0;
      cfg_we <= 1'b0;
      cfg_wdata <= '0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_pct);
      if (!(in_valid && !in_ready)) begin
        if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending[0].kind == JOB_ITEM) begin
          recv_pct = pending[0].recv_pct;
          if ($urandom_range(99) >= pending[0].send_pct) begin
            in_valid <= 1'b1;
            in_data <= pending[0].item;
            void'(pending.pop_front());
          end else begin
            in_valid <= 1'b0;
          end
        end else begin
          in_valid <= 1'b0;
          if (!in_valid && expected_results.size() == 0) begin
            if (pending[0].kind == JOB_CFG) begin
              cfg_now = 1'b1;
              cfg_wdata <= pending[0].cref;
            end
            void'(pending.pop_front());
          end
        end
      end
      cfg_we <= cfg_now;
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (cfg_we) begin
        cref_ff = cfg_wdata;
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        predict_meter(in_data);
        items_in++;
      end
      if (out_valid && out_ready) begin
        results_out++;
        if (expected_results.size() == 0) begin
          report("unexpected item", 64'(out_data.value), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.value !== want.value)
            report("value", 64'(out_data.value), 64'(want.value));
          if (out_data.decade !== want.decade)
            report("decade", 64'(out_data.decade), 64'(want.decade));
          if (out_data.status !== want.status)
            report("status", 64'(out_data.status), 64'(want.status));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (pending.size() == 0 && expected_results.size() == 0))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("timeout waiting on the block");
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase, n, k;
    logic [CountBits-1:0] f1;
    cref_ff = CrefReset;
    f1_count = '0;
    cs_ff = '0;
    ls_ph = '0;
    recv_pct = 0;
    fill_send = 0;
    fill_recv = 0;

    // directed
    push_item(MODE_CAL, 24'd1000);
    push_item(MODE_IND, 24'd0);
    push_item(MODE_IND, 24'd2);
    push_item(MODE_CAP, 24'd0);
    push_item(MODE_REF, 24'd1000);
    push_item(MODE_CAL, 24'd1000);
    push_item(MODE_CAL, 24'd900);
    push_item(MODE_IND, 24'd3);
    push_item(MODE_IND, 24'd500);
    push_item(MODE_IND, 24'd16777215);
    push_item(MODE_CAP, 24'd1);
    push_item(MODE_CAP, 24'd1000);
    push_item(MODE_CAP, 24'd2000);
    push_item(MODE_REF, 24'd900);
    push_item(MODE_CAL, 24'd1000);
    push_item(MODE_IND, 24'd500);
    push_item(MODE_CAP, 24'd500);
    push_ctrl(JOB_CFG, CrefMax);
    push_item(MODE_REF, 24'd16777215);
    push_item(MODE_CAL, 24'd16777214);
    push_item(MODE_CAP, 24'd1);
    push_item(MODE_IND, 24'd3);
    push_ctrl(JOB_CFG, CrefBits'(1));
    push_item(MODE_REF, 24'd1000);
    push_item(MODE_CAL, 24'd1);
    push_item(MODE_CAP, 24'd16777215);

    // random, four idling phases
    for (phase = 0; phase < 4; phase++) begin
      fill_send = (phase == 1 || phase == 3) ? (phase == 1 ? 72 : 34) : 0;
      fill_recv = (phase == 2 || phase == 3) ? (phase == 2 ? 72 : 34) : 0;
      n = 0;
      while (n < 445) begin
        if (n % 150 == 0)
          case ($urandom_range(3))
            0: push_ctrl(JOB_CFG, CrefBits'(1));
            1: push_ctrl(JOB_CFG, CrefMax);
            2: push_ctrl(JOB_CFG, CrefReset);
            default: push_ctrl(JOB_CFG, CrefBits'($urandom_range(1000000000, 1)));
          endcase
        if ($urandom_range(99) < 3) push_ctrl(JOB_PAUSE, '0);
        if ($urandom_range(99) < 85) begin
          f1 = rand_count();
          push_item(MODE_REF, f1);
          push_item(MODE_CAL, $urandom_range(1) ? f1 - CountBits'($urandom_range(f1 / 2))
                                                : rand_count());
          k = $urandom_range(8, 1);
          n += 2 + k;
          repeat (k) push_item($urandom_range(1) ? MODE_IND : MODE_CAP, rand_count());
        end else begin
          push_item(2'($urandom_range(3)), CountBits'($urandom));
          n++;
        end
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (expected_results.size() != 0)
      report("items left over", 64'(expected_results.size()), 64'd0);
    $display("checked %0d results from %0d items across four idling phases",
             results_out, items_in);
    $display("reference capacitor written %0d times incl. both extremes", cfg_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lcm_pkg.sv
rtl/core/lcm_mul.sv
rtl/core/lcm_div.sv
rtl/core/lc_meter_calculator.sv
bench/lc_meter_calculator_tb.sv
